/* rtl/can_bit_timing_search_macros.svh */
// Assertion macros for the CAN bit timing search RTL.
`ifndef CAN_BIT_TIMING_SEARCH_MACROS_SVH
`define CAN_BIT_TIMING_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define CBTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbts: same-cycle check failed");
`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbts: next-cycle check failed");
`else
`define CBTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/cbts_pkg.sv */
// Shared widths, limits, command codes and status bundle of the bit timing search.
package cbts_pkg;

  localparam int KCLK_W    = 29;
  localparam int RATE_W    = 24;
  localparam int SP_W      = 10;
  localparam int PRE_OUT_W = 9;
  localparam int SEG1_W    = 8;
  localparam int SEG2_W    = 7;
  localparam int SJW_W     = 7;

  localparam logic [KCLK_W-1:0] KCLK_RESET = 29'd80000000;

  localparam int MIN_QUANTA = 4;
  localparam int SEG1_LIMIT = 128;
  localparam int SEG2_LIMIT = 64;
  localparam logic [SJW_W-1:0] SJW_LIMIT = 7'd64;
  localparam int PERMILLE   = 1000;

  // Division by the permille scale is a multiply by a rounded-up reciprocal.
  // It is exact for every sample point times quanta product below 2^21.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 21;
  localparam longint RECIP_FULL =
    ((longint'(1) << RECIP_SHIFT) + longint'(PERMILLE) - 1) / longint'(PERMILLE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_DEN,
    OP_DIV_TQ,
    OP_LATCH_TQ,
    OP_MUL_X,
    OP_MUL_HEAD,
    OP_MUL_PT,
    OP_DIV_ACT,
    OP_UPDATE,
    OP_NEXT,
    OP_OUT
  } cbts_op_t;

  typedef struct packed {
    logic div_done;
    logic rate_zero;
    logic tq_low;
    logic tq_high;
    logic seg_ok;
    logic exact;
    logic last_p;
  } cbts_status_t;

endpackage

/* rtl/cbts_div.sv */
// Restoring divider that retires one quotient bit per cycle.
module cbts_div import cbts_pkg::*; #(
  parameter int NW = 29,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, num[NW-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits fill in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      num <= {num[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient = num;

endmodule

/* rtl/cbts_dp.sv */
// Datapath of the bit timing search: operands, multipliers, divider and best candidate.
module cbts_dp import cbts_pkg::*; #(
  parameter int PRESCALER_MAX = 256,
  parameter int MAX_QUANTA    = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [KCLK_W-1:0]   cfg_wdata,
  input  logic [RATE_W-1:0]   target_rate_hz,
  input  logic [SP_W-1:0]     sample_point_permille,
  input  cbts_op_t            op,
  output cbts_status_t        status,
  output logic [PRE_OUT_W-1:0] prescaler_out,
  output logic [SEG1_W-1:0]   phase_seg1,
  output logic [SEG2_W-1:0]   phase_seg2,
  output logic [SJW_W-1:0]    jump_width,
  output logic                found
);

  localparam int PW  = $clog2(PRESCALER_MAX + 1);
  localparam int QW  = $clog2(MAX_QUANTA + 1);
  localparam int DW  = PW + RATE_W;
  localparam int XW  = SP_W + QW;
  localparam int HW  = QW + 1;
  localparam int TW  = PW + QW;
  localparam int HPW = XW + RECIP_W;

  logic [KCLK_W-1:0] kclk;
  logic [RATE_W-1:0] rate;
  logic [SP_W-1:0]   sp;
  logic [PW-1:0]     p;
  logic [DW-1:0]     den;
  logic [QW-1:0]     tq;
  logic              tq_low_r;
  logic              tq_high_r;
  logic [XW-1:0]     x;
  logic [HW-1:0]     head;
  logic [TW-1:0]     pt;
  logic [SEG1_W-1:0] s1_c;
  logic [SEG2_W-1:0] s2_c;

  logic              have;
  logic [KCLK_W-1:0] best_err;
  logic [PW-1:0]     best_p;
  logic [SEG1_W-1:0] best_s1;
  logic [SEG2_W-1:0] best_s2;

  logic              div_start;
  logic [DW-1:0]     div_divisor;
  logic              div_done;
  logic [KCLK_W-1:0] div_q;

  logic [DW-1:0]     den_prod;
  logic [XW-1:0]     x_prod;
  logic [HPW-1:0]    head_prod;
  logic [TW-1:0]     pt_prod;
  logic [31:0]       head_w;
  logic [31:0]       tq_w;
  logic [31:0]       s1_w;
  logic [31:0]       s2_w;
  logic              seg_ok;
  logic [KCLK_W-1:0] rate_x;
  logic [KCLK_W-1:0] err_now;
  logic              better;
  logic [PW+PRE_OUT_W-1:0] p_wide;

  always_comb begin
    den_prod  = DW'(p) * DW'(rate);
    x_prod    = XW'(sp) * XW'(tq);
    head_prod = HPW'(x) * HPW'(RECIP);
    pt_prod   = TW'(p) * TW'(tq);

    // A valid split needs 2 <= head <= 129, head < tq and tq - head <= 64.
    head_w = 32'(head);
    tq_w   = 32'(tq);
    s1_w   = head_w - 32'd1;
    s2_w   = tq_w - head_w;
    seg_ok = (head_w >= 32'd2) && (head_w <= 32'(SEG1_LIMIT + 1)) &&
             (head_w < tq_w) && (s2_w <= 32'(SEG2_LIMIT));

    rate_x  = KCLK_W'(rate);
    err_now = (div_q > rate_x) ? (div_q - rate_x) : (rate_x - div_q);
    better  = !have || (err_now < best_err);

    div_start   = (op == OP_DIV_TQ) || (op == OP_DIV_ACT);
    div_divisor = (op == OP_DIV_ACT) ? DW'(pt) : den;

    p_wide = {{PRE_OUT_W{1'b0}}, best_p};
  end

  cbts_div #(
    .NW (KCLK_W),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (kclk),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kclk <= KCLK_RESET;
    end else if (cfg_we) begin
      kclk <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        rate     <= target_rate_hz;
        sp       <= sample_point_permille;
        p        <= PW'(1);
        have     <= 1'b0;
        best_err <= '0;
        best_p   <= '0;
        best_s1  <= '0;
        best_s2  <= '0;
      end
      OP_MUL_DEN: begin
        den <= den_prod;
      end
      OP_LATCH_TQ: begin
        tq        <= div_q[QW-1:0];
        tq_low_r  <= div_q < KCLK_W'(MIN_QUANTA);
        tq_high_r <= div_q > KCLK_W'(MAX_QUANTA);
      end
      OP_MUL_X: begin
        x <= x_prod;
      end
      OP_MUL_HEAD: begin
        head <= head_prod[RECIP_SHIFT +: HW];
      end
      OP_MUL_PT: begin
        pt   <= pt_prod;
        s1_c <= s1_w[SEG1_W-1:0];
        s2_c <= s2_w[SEG2_W-1:0];
      end
      OP_UPDATE: begin
        if (better) begin
          have     <= 1'b1;
          best_err <= err_now;
          best_p   <= p;
          best_s1  <= s1_c;
          best_s2  <= s2_c;
        end
      end
      OP_NEXT: begin
        p <= p + PW'(1);
      end
      OP_OUT: begin
        prescaler_out <= p_wide[PRE_OUT_W-1:0];
        phase_seg1    <= best_s1;
        phase_seg2    <= best_s2;
        jump_width    <= (best_s2 < SJW_LIMIT) ? best_s2 : SJW_LIMIT;
        found         <= have;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.div_done  = div_done;
    status.rate_zero = (rate == '0);
    status.tq_low    = tq_low_r;
    status.tq_high   = tq_high_r;
    status.seg_ok    = seg_ok;
    status.exact     = (err_now == '0);
    status.last_p    = (p == PW'(PRESCALER_MAX));
  end

endmodule

/* rtl/cbts_ctrl.sv */
// Controller of the bit timing search: walks the prescalers and owns both handshakes.
module cbts_ctrl import cbts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  cbts_status_t status,
  output cbts_op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEN,
    S_DIV_TQ,
    S_WAIT_TQ,
    S_CHECK_TQ,
    S_HEAD,
    S_SEG,
    S_DIV_ACT,
    S_WAIT_ACT,
    S_ADVANCE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    op         = OP_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (status.rate_zero) begin
          state_next = S_FINISH;
        end else begin
          op         = OP_MUL_DEN;
          state_next = S_DIV_TQ;
        end
      end
      S_DIV_TQ: begin
        op         = OP_DIV_TQ;
        state_next = S_WAIT_TQ;
      end
      S_WAIT_TQ: begin
        if (status.div_done) begin
          op         = OP_LATCH_TQ;
          state_next = S_CHECK_TQ;
        end
      end
      S_CHECK_TQ: begin
        // Quanta only shrink as the prescaler grows, so too few ends the search.
        priority if (status.tq_low) begin
          state_next = S_FINISH;
        end else if (status.tq_high) begin
          state_next = S_ADVANCE;
        end else begin
          op         = OP_MUL_X;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        op         = OP_MUL_HEAD;
        state_next = S_SEG;
      end
      S_SEG: begin
        if (status.seg_ok) begin
          op         = OP_MUL_PT;
          state_next = S_DIV_ACT;
        end else begin
          state_next = S_ADVANCE;
        end
      end
      S_DIV_ACT: begin
        op         = OP_DIV_ACT;
        state_next = S_WAIT_ACT;
      end
      S_WAIT_ACT: begin
        if (status.div_done) begin
          op         = OP_UPDATE;
          state_next = status.exact ? S_FINISH : S_ADVANCE;
        end
      end
      S_ADVANCE: begin
        if (status.last_p) begin
          state_next = S_FINISH;
        end else begin
          op         = OP_NEXT;
          state_next = S_DEN;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/can_bit_timing_search.sv */
// CAN bit timing search: for a requested bit rate and sample point it tries
// prescalers from 1 upward and returns the first one with the smallest rate
// error, with its two segment lengths and jump width, or all zeros with found
// low. One request is worked on at a time. Every candidate needs one or two
// divisions on a single restoring divider that produces one quotient bit per
// cycle, and the search waits for each division to finish. The search ends
// early on an exact match or once the quanta count falls below four. The
// finished result sits in an output register, so the next request is taken
// while it waits. The kernel clock register may only be written while idle.
`include "can_bit_timing_search_macros.svh"

module can_bit_timing_search import cbts_pkg::*; #(
  parameter int PRESCALER_MAX = 256,
  parameter int MAX_QUANTA    = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [KCLK_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RATE_W-1:0]    target_rate_hz,
  input  logic [SP_W-1:0]      sample_point_permille,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PRE_OUT_W-1:0] prescaler_out,
  output logic [SEG1_W-1:0]    phase_seg1,
  output logic [SEG2_W-1:0]    phase_seg2,
  output logic [SJW_W-1:0]     jump_width,
  output logic                 found
);

  cbts_op_t     op;
  cbts_status_t status;

  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  cbts_dp #(
    .PRESCALER_MAX (PRESCALER_MAX),
    .MAX_QUANTA    (MAX_QUANTA)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .target_rate_hz        (target_rate_hz),
    .sample_point_permille (sample_point_permille),
    .op                    (op),
    .status                (status),
    .prescaler_out         (prescaler_out),
    .phase_seg1            (phase_seg1),
    .phase_seg2            (phase_seg2),
    .jump_width            (jump_width),
    .found                 (found)
  );

  // Once a request is taken, no other one enters until its search is over.
  `CBTS_ASSERT_NEXT(a_one_request, clk, rst, in_valid && !in_stall, in_stall)
  `CBTS_ASSERT_IMPL(a_found_flag, clk, rst, out_valid, found == (prescaler_out != '0))
  `CBTS_ASSERT_IMPL(a_seg_ranges, clk, rst, out_valid && found, (|phase_seg1) && (|phase_seg2))
  `CBTS_ASSERT_IMPL(a_sjw_copy, clk, rst, out_valid, jump_width == phase_seg2)

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the CAN bit timing search block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbts_pkg::*;

  localparam int PRESCALER_MAX = 256;
  localparam int MAX_QUANTA    = 256;
  localparam int SEARCH_CYCLES = 68 * PRESCALER_MAX + 4;
  localparam int MAX_GAP       = 3000;
  localparam int MAX_STALL     = 400;
  localparam int ITEM_BUDGET   = 150;
  localparam int SETTLE_CYCLES = 64;
  localparam longint CYCLE_LIMIT =
    longint'(ITEM_BUDGET) * (SEARCH_CYCLES + MAX_GAP + MAX_STALL) * 4;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [SP_W-1:0]   sp;
  } request_t;

  typedef struct packed {
    logic [PRE_OUT_W-1:0] pre;
    logic [SEG1_W-1:0]    seg1;
    logic [SEG2_W-1:0]    seg2;
    logic [SJW_W-1:0]     sjw;
    logic                 found;
  } timing_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [KCLK_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RATE_W-1:0]    target_rate_hz = '0;
  logic [SP_W-1:0]      sample_point_permille = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PRE_OUT_W-1:0] prescaler_out;
  logic [SEG1_W-1:0]    phase_seg1;
  logic [SEG2_W-1:0]    phase_seg2;
  logic [SJW_W-1:0]     jump_width;
  logic                 found;

  request_t          request_q[$];
  timing_t           timing_q[$];
  logic [KCLK_W-1:0] kclk_now = KCLK_RESET;
  int                mismatches = 0;
  longint            cycles = 0;
  int                gap_left = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;

  can_bit_timing_search #(
    .PRESCALER_MAX(PRESCALER_MAX),
    .MAX_QUANTA   (MAX_QUANTA)
  ) i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .target_rate_hz       (target_rate_hz),
    .sample_point_permille(sample_point_permille),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .prescaler_out        (prescaler_out),
    .phase_seg1           (phase_seg1),
    .phase_seg2           (phase_seg2),
    .jump_width           (jump_width),
    .found                (found)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walks prescalers upward and keeps the first one with the smallest rate error.
  function automatic timing_t search_timing(logic [RATE_W-1:0] rate, logic [SP_W-1:0] sp,
                                            logic [KCLK_W-1:0] kclk);
    longint unsigned r, s, k, p, tq, head, s1, s2, actual, err, best_err;
    bit have, done;
    timing_t best;
    r = rate;
    s = sp;
    k = kclk;
    have = 1'b0;
    done = 1'b0;
    best_err = 0;
    best = '0;
    for (p = 1; p <= PRESCALER_MAX && !done && r != 0; p++) begin
      tq = k / (p * r);
      if (tq >= MIN_QUANTA && tq <= MAX_QUANTA) begin
        head = (s * tq) / PERMILLE;
        // A sample point at or past the bit end leaves no room for seg2.
        if (head >= 1 && head - 1 <= tq - 1) begin
          s1 = head - 1;
          s2 = tq - 1 - s1;
          if (s1 >= 1 && s1 <= SEG1_LIMIT && s2 >= 1 && s2 <= SEG2_LIMIT) begin
            actual = k / (p * tq);
            err = (actual > r) ? actual - r : r - actual;
            if (!have || err < best_err) begin
              have = 1'b1;
              best_err = err;
              best.pre = p[PRE_OUT_W-1:0];
              best.seg1 = s1[SEG1_W-1:0];
              best.seg2 = s2[SEG2_W-1:0];
              best.sjw = (s2 < SJW_LIMIT) ? s2[SJW_W-1:0] : SJW_LIMIT;
              best.found = 1'b1;
            end
            if (err == 0) begin
              done = 1'b1;
            end
          end
        end
      end
    end
    return best;
  endfunction

  // Mostly rates that some prescaler and quanta count can hit, the rest noise.
  function automatic request_t random_request(logic [KCLK_W-1:0] kclk);
    request_t req;
    longint unsigned rate;
    logic [31:0] word;
    int p, tq;
    if ($urandom_range(0, 3) != 0 && kclk != 0) begin
      p = $urandom_range(1, 16);
      tq = $urandom_range(8, 160);
      rate = kclk / (p * tq);
      if ($urandom_range(0, 2) == 0) begin
        rate = rate + $urandom_range(0, 32'(rate / 16));
      end
      if (rate == 0) begin
        rate = 1;
      end
      if (rate > 24'hFFFFFF) begin
        rate = 24'hFFFFFF;
      end
      req.rate = rate[RATE_W-1:0];
      req.sp = SP_W'($urandom_range(500, 950));
    end else begin
      word = $urandom();
      req.rate = $urandom_range(0, 1) ? word[RATE_W-1:0] : RATE_W'($urandom_range(1, 2000000));
      word = $urandom();
      req.sp = word[SP_W-1:0];
    end
    return req;
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 50);
      8:          return $urandom_range(51, 600);
      default:    return $urandom_range(601, MAX_GAP);
    endcase
  endfunction

  // Waits until every request has been taken and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || timing_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_kclk(logic [KCLK_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    kclk_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        timing_q.push_back(search_timing(target_rate_hz, sample_point_permille, kclk_now));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          target_rate_hz <= request_q[0].rate;
          sample_point_permille <= request_q[0].sp;
          void'(request_q.pop_front());
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 7);
            gap_left = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    timing_t want, got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{prescaler_out, phase_seg1, phase_seg2, jump_width, found};
        if (timing_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: pre %0d seg1 %0d seg2 %0d sjw %0d found %0b",
                     got.pre, got.seg1, got.seg2, got.sjw, got.found);
          end
          mismatches++;
        end else begin
          want = timing_q.pop_front();
          if (got.pre !== want.pre || got.seg1 !== want.seg1 || got.seg2 !== want.seg2 ||
              got.sjw !== want.sjw || got.found !== want.found) begin
            if (mismatches < 10) begin
              $display("mismatch: expected pre %0d seg1 %0d seg2 %0d sjw %0d found %0b",
                       want.pre, want.seg1, want.seg2, want.sjw, want.found);
              $display("          actual   pre %0d seg1 %0d seg2 %0d sjw %0d found %0b",
                       got.pre, got.seg1, got.seg2, got.sjw, got.found);
            end
            mismatches++;
          end
        end
      end
      // The receiver alternates between open stretches, random stalls and solid stalls.
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(1, MAX_STALL);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
        2:       out_stall <= $urandom_range(0, 1);
        3:       out_stall <= 1'b1;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [KCLK_W-1:0] kclk_list[$];
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests against the kernel clock left by reset.
    request_q.push_back('{24'd500000, 10'd875});
    request_q.push_back('{24'd1000000, 10'd750});
    request_q.push_back('{24'd250000, 10'd875});
    request_q.push_back('{24'd125000, 10'd800});
    request_q.push_back('{24'd83333, 10'd875});
    request_q.push_back('{24'd0, 10'd875});
    request_q.push_back('{24'hFFFFFF, 10'h3FF});
    request_q.push_back('{24'd16000000, 10'd500});
    request_q.push_back('{24'd1, 10'd875});
    request_q.push_back('{24'd500000, 10'd0});
    request_q.push_back('{24'd500000, 10'd1023});
    request_q.push_back('{24'd500000, 10'd1});
    request_q.push_back('{24'd500000, 10'd999});
    request_q.push_back('{24'd500000, 10'd1000});
    request_q.push_back('{24'd500000, 10'd100});
    request_q.push_back('{24'd10000, 10'd500});
    request_q.push_back('{24'd33333, 10'd682});
    request_q.push_back('{24'd800000, 10'd341});
    request_q.push_back('{24'd20000, 10'd900});

    kclk_list = '{29'd80000000, 29'd1000000, 29'd500000000, 29'd0, 29'h1FFFFFFF,
                  29'd24000000, 29'd1000000, 29'd1000000};
    kclk_list[6] = KCLK_W'($urandom_range(1000000, 500000000));
    kclk_list[7] = KCLK_W'($urandom_range(1000000, 500000000));

    foreach (kclk_list[i]) begin
      drain();
      write_kclk(kclk_list[i]);
      // With no kernel clock every request fails, so a few are enough.
      n = (kclk_list[i] == 0) ? 4 : 14;
      repeat (n) request_q.push_back(random_request(kclk_list[i]));
    end

    drain();
    if (mismatches == 0 && timing_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
